// ----- sv/cda_pkg.sv -----
// Shared types, constants and the control program of the calendar date adder.
// No dependencies; the datapath and the top level import this package.
package cda_pkg;

  localparam int unsigned YEAR_BITS   = 16;
  localparam int unsigned AMOUNT_BITS = 16;
  localparam int unsigned MONTH_BITS  = 4;
  localparam int unsigned DAY_BITS    = 5;
  localparam int unsigned ACTION_BITS = 2;

  // Month plus amount; also the numerator of the divide by twelve.
  localparam int unsigned SUM_BITS    = AMOUNT_BITS + 1;
  // Reciprocal of twelve, rounded up, with enough guard bits that the
  // truncated product equals the true quotient for every SUM_BITS value.
  localparam int unsigned RECIP_SHIFT = SUM_BITS + 4;
  localparam int unsigned RECIP_BITS  = SUM_BITS + 1;
  localparam logic [RECIP_BITS-1:0] RECIP_12 =
    RECIP_BITS'((64'd1 << RECIP_SHIFT) / 64'd12 + 64'd1);
  localparam int unsigned PROD_BITS   = SUM_BITS + RECIP_BITS;

  localparam logic [MONTH_BITS-1:0] MONTH_FEB = MONTH_BITS'(2);
  localparam logic [MONTH_BITS-1:0] MONTH_APR = MONTH_BITS'(4);
  localparam logic [MONTH_BITS-1:0] MONTH_JUN = MONTH_BITS'(6);
  localparam logic [MONTH_BITS-1:0] MONTH_SEP = MONTH_BITS'(9);
  localparam logic [MONTH_BITS-1:0] MONTH_NOV = MONTH_BITS'(11);
  localparam int unsigned MONTHS_PER_YEAR = 12;

  localparam logic [DAY_BITS-1:0] LEN_LEAP_FEB = DAY_BITS'(29);
  localparam logic [DAY_BITS-1:0] LEN_FEB      = DAY_BITS'(28);
  localparam logic [DAY_BITS-1:0] LEN_SHORT    = DAY_BITS'(30);
  localparam logic [DAY_BITS-1:0] LEN_LONG     = DAY_BITS'(31);

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_SET        = 2'd0,
    ACT_ADD_DAYS   = 2'd1,
    ACT_ADD_MONTHS = 2'd2,
    ACT_ADD_YEARS  = 2'd3
  } action_e;

  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic [YEAR_BITS-1:0]   new_year;
    logic [MONTH_BITS-1:0]  new_month;
    logic [DAY_BITS-1:0]    new_day;
    logic [AMOUNT_BITS-1:0] amount;
  } cda_req_t;

  typedef struct packed {
    logic [YEAR_BITS-1:0]  cur_year;
    logic [MONTH_BITS-1:0] cur_month;
    logic [DAY_BITS-1:0]   cur_day;
  } cda_rsp_t;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_WAIT,
    OP_NOP,
    OP_SET,
    OP_DAY_INIT,
    OP_DAY_STEP,
    OP_MON_SUM,
    OP_MON_MUL,
    OP_MON_APPLY,
    OP_YEARS,
    OP_EMIT
  } op_e;

  // How the step counter moves after a control word.
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_GOTO,
    COND_DISPATCH,
    COND_LEFT_ZERO,
    COND_OUT_FREE
  } cond_e;

  localparam int unsigned STEP_BITS = 4;
  typedef logic [STEP_BITS-1:0] step_t;

  localparam step_t STEP_WAIT      = 4'd0;
  localparam step_t STEP_TABLE     = 4'd1;  // four jump slots, one per action
  localparam step_t STEP_SET       = 4'd5;
  localparam step_t STEP_DAY_INIT  = 4'd6;
  localparam step_t STEP_DAY_STEP  = 4'd7;
  localparam step_t STEP_MON_SUM   = 4'd8;
  localparam step_t STEP_MON_MUL   = 4'd9;
  localparam step_t STEP_MON_APPLY = 4'd10;
  localparam step_t STEP_YEARS     = 4'd11;
  localparam step_t STEP_EMIT      = 4'd12;

  localparam step_t STEP_SLOT_SET    = STEP_TABLE + step_t'(ACT_SET);
  localparam step_t STEP_SLOT_DAYS   = STEP_TABLE + step_t'(ACT_ADD_DAYS);
  localparam step_t STEP_SLOT_MONTHS = STEP_TABLE + step_t'(ACT_ADD_MONTHS);
  localparam step_t STEP_SLOT_YEARS  = STEP_TABLE + step_t'(ACT_ADD_YEARS);

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ctrl_word_t;

  // Control to the datapath.
  typedef struct packed {
    op_e  op;
    logic accept;
  } cda_ctrl_t;

  // Status back from the datapath.
  typedef struct packed {
    logic     left_zero;
    cda_rsp_t date;
  } cda_stat_t;

  // Microcode store.
  function automatic ctrl_word_t cda_program(step_t pc);
    ctrl_word_t w;
    w = '{op: OP_WAIT, cond: COND_GOTO, target: STEP_WAIT};
    unique case (pc)
      STEP_WAIT:        w = '{op: OP_WAIT,      cond: COND_DISPATCH,  target: STEP_TABLE};
      STEP_SLOT_SET:    w = '{op: OP_NOP,       cond: COND_GOTO,      target: STEP_SET};
      STEP_SLOT_DAYS:   w = '{op: OP_NOP,       cond: COND_GOTO,      target: STEP_DAY_INIT};
      STEP_SLOT_MONTHS: w = '{op: OP_NOP,       cond: COND_GOTO,      target: STEP_MON_SUM};
      STEP_SLOT_YEARS:  w = '{op: OP_NOP,       cond: COND_GOTO,      target: STEP_YEARS};
      STEP_SET:         w = '{op: OP_SET,       cond: COND_GOTO,      target: STEP_EMIT};
      STEP_DAY_INIT:    w = '{op: OP_DAY_INIT,  cond: COND_NEXT,      target: STEP_DAY_STEP};
      STEP_DAY_STEP:    w = '{op: OP_DAY_STEP,  cond: COND_LEFT_ZERO, target: STEP_EMIT};
      STEP_MON_SUM:     w = '{op: OP_MON_SUM,   cond: COND_NEXT,      target: STEP_MON_MUL};
      STEP_MON_MUL:     w = '{op: OP_MON_MUL,   cond: COND_NEXT,      target: STEP_MON_APPLY};
      STEP_MON_APPLY:   w = '{op: OP_MON_APPLY, cond: COND_GOTO,      target: STEP_EMIT};
      STEP_YEARS:       w = '{op: OP_YEARS,     cond: COND_GOTO,      target: STEP_EMIT};
      STEP_EMIT:        w = '{op: OP_EMIT,      cond: COND_OUT_FREE,  target: STEP_WAIT};
      default:          w = '{op: OP_WAIT,      cond: COND_GOTO,      target: STEP_WAIT};
    endcase
    return w;
  endfunction

  // February follows the divisible-by-four rule; unknown months count as 31.
  function automatic logic [DAY_BITS-1:0] month_length(logic [1:0] year_lo,
                                                       logic [MONTH_BITS-1:0] month);
    logic [DAY_BITS-1:0] len;
    len = LEN_LONG;
    if (month == MONTH_FEB) begin
      len = (year_lo == 2'b00) ? LEN_LEAP_FEB : LEN_FEB;
    end else if (month == MONTH_APR || month == MONTH_JUN ||
                 month == MONTH_SEP || month == MONTH_NOV) begin
      len = LEN_SHORT;
    end
    return len;
  endfunction

endpackage

// ----- sv/cda_datapath.sv -----
// Date registers and arithmetic of the calendar date adder.
// Driven one operation per cycle by the sequencer; depends on cda_pkg.
module cda_datapath
  import cda_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cda_ctrl_t ctrl_i,
  input  cda_req_t  req_i,
  output cda_stat_t stat_o
);

  logic [YEAR_BITS-1:0]   year_q, year_d;
  logic [MONTH_BITS-1:0]  month_q, month_d;
  logic [DAY_BITS-1:0]    day_q, day_d;

  cda_req_t               cmd_q, cmd_d;
  logic [AMOUNT_BITS-1:0] left_q, left_d;
  logic [SUM_BITS-1:0]    sum_q, sum_d;
  logic [PROD_BITS-1:0]   prod_q, prod_d;

  // Day walk, one month per step.
  logic [DAY_BITS-1:0]    len;
  logic [DAY_BITS-1:0]    dclamp;
  logic [SUM_BITS-1:0]    walk_sum;
  logic [DAY_BITS:0]      consumed;
  logic [MONTH_BITS:0]    month_nx;
  logic                   left_zero;

  // Month add.
  logic [SUM_BITS-1:0]    quot;
  logic [SUM_BITS-1:0]    times12;
  logic [SUM_BITS-1:0]    month_rem;

  assign left_zero = (left_q == '0);

  always_comb begin
    len      = month_length(year_q[1:0], month_q);
    dclamp   = (day_q > len) ? len : day_q;
    walk_sum = SUM_BITS'(left_q) + SUM_BITS'(dclamp);
    consumed = (DAY_BITS+1)'(len) - (DAY_BITS+1)'(dclamp) + (DAY_BITS+1)'(1);
    quot     = SUM_BITS'(prod_q >> RECIP_SHIFT);
    times12  = (quot << 3) + (quot << 2);
    month_rem = sum_q - times12;
  end

  always_comb begin
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    cmd_d    = cmd_q;
    left_d   = left_q;
    sum_d    = sum_q;
    prod_d   = prod_q;
    month_nx = {1'b0, month_q};
    unique case (ctrl_i.op)
      OP_WAIT: begin
        if (ctrl_i.accept) begin
          cmd_d = req_i;
        end
      end
      OP_SET: begin
        year_d  = cmd_q.new_year;
        month_d = cmd_q.new_month;
        day_d   = cmd_q.new_day;
      end
      OP_DAY_INIT: begin
        left_d = cmd_q.amount;
      end
      OP_DAY_STEP: begin
        if (!left_zero) begin
          if (walk_sum > SUM_BITS'(len)) begin
            // Spill into the next month.
            left_d   = left_q - AMOUNT_BITS'(consumed);
            month_nx = {1'b0, month_q} + (MONTH_BITS+1)'(1);
            day_d    = DAY_BITS'(1);
          end else begin
            day_d  = walk_sum[DAY_BITS-1:0];
            left_d = '0;
          end
          if (month_nx > (MONTH_BITS+1)'(MONTHS_PER_YEAR)) begin
            year_d  = year_q + YEAR_BITS'(1);
            month_d = MONTH_BITS'(1);
          end else begin
            month_d = month_nx[MONTH_BITS-1:0];
          end
        end
      end
      OP_MON_SUM: begin
        sum_d = SUM_BITS'(month_q) + SUM_BITS'(cmd_q.amount);
      end
      OP_MON_MUL: begin
        // (t - 1) / 12 by reciprocal; product registered before use.
        prod_d = PROD_BITS'(sum_q - SUM_BITS'(1)) * PROD_BITS'(RECIP_12);
      end
      OP_MON_APPLY: begin
        if (sum_q > SUM_BITS'(MONTHS_PER_YEAR)) begin
          year_d  = year_q + YEAR_BITS'(quot);
          month_d = month_rem[MONTH_BITS-1:0];
        end else begin
          month_d = sum_q[MONTH_BITS-1:0];
        end
      end
      OP_YEARS: begin
        year_d = year_q + YEAR_BITS'(cmd_q.amount);
      end
      OP_NOP, OP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q  <= '0;
      month_q <= MONTH_BITS'(1);
      day_q   <= DAY_BITS'(1);
    end else begin
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    left_q <= left_d;
    sum_q  <= sum_d;
    prod_q <= prod_d;
  end

  assign stat_o.left_zero      = left_zero;
  assign stat_o.date.cur_year  = year_q;
  assign stat_o.date.cur_month = month_q;
  assign stat_o.date.cur_day   = day_q;

endmodule

// ----- sv/calendar_date_adder_unit.sv -----
// Calendar date adder: microcoded sequencer, output register, datapath.
// Each request runs the program steps of its action; add days repeats a walk
// step until no days remain (a step ends a month or lands on the final day).
// One request at a time; the next request is taken once the result is loaded.
// Reset (async, active low) gives 0000-01-01 and an empty output register.
// Depends on cda_pkg and cda_datapath.
module calendar_date_adder_unit
  import cda_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  cda_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output cda_rsp_t out_rsp_o
);

  // Step counter and the control word it selects.
  step_t      pc_q, pc_d;
  ctrl_word_t cw;

  cda_ctrl_t  ctrl;
  cda_stat_t  stat;

  logic       accept;
  logic       out_free;
  logic       emit_load;

  logic       out_valid_q, out_valid_d;
  cda_rsp_t   out_rsp_q;

  assign cw = cda_program(pc_q);

  // Take a request only while the program sits in its wait step.
  assign in_stall_o = (cw.op != OP_WAIT);
  assign accept     = in_valid_i && (cw.op == OP_WAIT);

  // The output slot can take a new result when empty or draining this cycle.
  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit_load = (cw.op == OP_EMIT) && out_free;

  assign ctrl.op     = cw.op;
  assign ctrl.accept = accept;

  // Advance the step counter.
  always_comb begin
    pc_d = pc_q;
    unique case (cw.cond)
      COND_NEXT:     pc_d = pc_q + STEP_BITS'(1);
      COND_GOTO:     pc_d = cw.target;
      COND_DISPATCH: begin
        // Jump into the action table, one slot per action.
        if (accept) begin
          pc_d = cw.target + STEP_BITS'(in_req_i.action);
        end
      end
      COND_LEFT_ZERO: begin
        // Hold on the walk step until no days remain.
        if (stat.left_zero) begin
          pc_d = cw.target;
        end
      end
      COND_OUT_FREE: begin
        if (out_free) begin
          pc_d = cw.target;
        end
      end
      default: pc_d = STEP_WAIT;
    endcase
  end

  // Output register: load on emit, drop once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= STEP_WAIT;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_rsp_q <= stat.date;
    end
  end

  cda_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .req_i  (in_req_i),
    .stat_o (stat)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
